[hdl/line_address_parser_assert.svh]
// assertion macros for the line address parser
`ifndef LINE_ADDRESS_PARSER_ASSERT_SVH
`define LINE_ADDRESS_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LAP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lap_pkg.sv]
// package with payload types, character codes and base kinds for the address parser
`timescale 1ns / 1ps
`default_nettype none

package lap_pkg;

  localparam int NUMBER_BITS_DEFAULT = 32;
  localparam int FIELD_W = 32;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7a;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5a;

  localparam logic [3:0] KIND_NONE     = 4'd0;
  localparam logic [3:0] KIND_CURRENT  = 4'd1;
  localparam logic [3:0] KIND_LAST     = 4'd2;
  localparam logic [3:0] KIND_BLK_FWD  = 4'd3;
  localparam logic [3:0] KIND_BLK_BACK = 4'd4;
  localparam logic [3:0] KIND_MARK     = 4'd5;
  localparam logic [3:0] KIND_PAT_FWD  = 4'd6;
  localparam logic [3:0] KIND_PAT_BACK = 4'd7;
  localparam logic [3:0] KIND_NUMBER   = 4'd8;

  localparam logic [1:0] BR_NONE   = 2'd0;
  localparam logic [1:0] BR_SINGLE = 2'd1;
  localparam logic [1:0] BR_DOUBLE = 2'd2;
  localparam logic [1:0] BR_OPEN   = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic                      consumed;
    logic                      done_res;
    logic                      error;
    logic [3:0]                base_kind;
    logic [7:0]                mark_letter;
    logic [FIELD_W-1:0]        line_number;
    logic signed [FIELD_W-1:0] offset;
    logic                      pattern_valid;
    logic [7:0]                pattern_char;
  } res_t;

endpackage

`default_nettype wire

[hdl/lap_offset_sat.sv]
// saturating signed add of one offset term to the running offset sum
`timescale 1ns / 1ps
`default_nettype none

module lap_offset_sat #(
  parameter int NB = 32
) (
  input  wire logic [NB-1:0] sum_in,
  input  wire logic [NB-1:0] term,
  input  wire logic          negative,
  output      logic [NB-1:0] sum_out
);

  localparam logic [NB-1:0] SIGN_BIT = {1'b1, {(NB-1){1'b0}}};

  logic [NB-1:0] biased;
  logic [NB:0]   add_w;
  logic [NB-1:0] res_b;

  always_comb begin
    biased = sum_in ^ SIGN_BIT;
    add_w  = {1'b0, biased} + {1'b0, term};
    if (negative) begin
      res_b = (term > biased) ? '0 : biased - term;
    end else begin
      res_b = add_w[NB] ? '1 : add_w[NB-1:0];
    end
    sum_out = res_b ^ SIGN_BIT;
  end

endmodule

`default_nettype wire

[hdl/line_address_parser.sv]
// top level: streaming ed-style line address parser, one byte per transaction
// an accepted byte is registered in the stage register, then moved into the result register
// throughput: one transaction per cycle unless the input stalls, set by the single parse stage feeding back on itself
// result register decouples output stall from input; input stalls only when both stages are full
// rst (synchronous) clears parser state and both pipeline valids; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module line_address_parser
  import lap_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output      logic cmd_ready,
  input  wire cmd_t cmd,
  output      logic res_valid,
  input  wire logic res_ready,
  output      res_t res
);

  `include "line_address_parser_assert.svh"

  localparam int NB = NUMBER_BITS;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_MARK    = 3'd1;
  localparam logic [2:0] PH_PATTERN = 3'd2;
  localparam logic [2:0] PH_NUMBER  = 3'd3;
  localparam logic [2:0] PH_POST    = 3'd4;
  localparam logic [2:0] PH_TSIGN   = 3'd5;
  localparam logic [2:0] PH_TDIGITS = 3'd6;

  localparam logic [NB-1:0] ONE = {{(NB-1){1'b0}}, 1'b1};

  // parser state
  logic [2:0]    phase, phase_next;
  logic [3:0]    kind, kind_next;
  logic [7:0]    mark, mark_next;
  logic [NB-1:0] line_reg, line_reg_next;
  logic [NB-1:0] offset_sum, offset_sum_next;
  logic [NB-1:0] term_value, term_value_next;
  logic          term_negative, term_negative_next;
  logic          term_has_digits, term_has_digits_next;
  logic [1:0]    bracket_mode, bracket_mode_next;
  logic          escape_pending, escape_pending_next;
  logic          prev_close, prev_close_next;

  // stage register between parse and result
  logic          s_valid;
  logic          s_consumed, s_finish, s_error, s_pv;
  logic [7:0]    s_ch;
  logic [3:0]    s_kind;
  logic [7:0]    s_mark;
  logic [NB-1:0] s_line, s_offset, s_term;
  logic          s_negative, s_digits, s_term_open;

  logic          accept, out_load;
  logic          blank, digit, sign, letter;
  logic          consumed, finish, err, pv;
  logic [7:0]    delim;
  logic [NB-1:0] applied_sum, ten_src, ten_val, final_sum;
  logic signed [NB-1:0] final_signed;
  res_t          res_next;

  function automatic logic [NB-1:0] mul10_add(input logic [NB-1:0] v, input logic [3:0] d);
    logic [NB+3:0] w;
    w = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{NB{1'b0}}, d};
    return (w[NB+3:NB] != 4'd0) ? '1 : w[NB-1:0];
  endfunction

  assign out_load  = !res_valid || res_ready;
  assign cmd_ready = !s_valid || out_load;
  assign accept    = cmd_valid && cmd_ready;

  assign blank  = cmd.ch inside {CH_SPACE, CH_TAB};
  assign digit  = cmd.ch inside {[CH_0:CH_9]};
  assign sign   = cmd.ch inside {CH_PLUS, CH_MINUS};
  assign letter = cmd.ch inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]};
  assign delim  = (kind == KIND_PAT_FWD) ? CH_SLASH : CH_QMARK;

  lap_offset_sat #(.NB(NB)) u_term_sat (
    .sum_in   (offset_sum),
    .term     (term_has_digits ? term_value : ONE),
    .negative (term_negative),
    .sum_out  (applied_sum)
  );

  assign ten_src = (phase == PH_NUMBER) ? line_reg :
                   (phase == PH_POST) ? '0 : term_value;
  assign ten_val = mul10_add(ten_src, cmd.ch[3:0]);

  always_comb begin
    phase_next           = phase;
    kind_next            = kind;
    mark_next            = mark;
    line_reg_next        = line_reg;
    offset_sum_next      = offset_sum;
    term_value_next      = term_value;
    term_negative_next   = term_negative;
    term_has_digits_next = term_has_digits;
    bracket_mode_next    = bracket_mode;
    escape_pending_next  = escape_pending;
    prev_close_next      = prev_close;
    consumed             = 1'b1;
    finish               = 1'b0;
    err                  = 1'b0;
    pv                   = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (blank) begin
        end else if (cmd.ch == CH_DOT) begin
          kind_next  = KIND_CURRENT;
          phase_next = PH_POST;
        end else if (cmd.ch == CH_DOLLAR) begin
          kind_next  = KIND_LAST;
          phase_next = PH_POST;
        end else if (cmd.ch == CH_RBRACK) begin
          kind_next  = KIND_BLK_FWD;
          phase_next = PH_POST;
        end else if (cmd.ch == CH_LBRACK) begin
          kind_next  = KIND_BLK_BACK;
          phase_next = PH_POST;
        end else if (cmd.ch == CH_QUOTE) begin
          phase_next = PH_MARK;
          err        = cmd.last;
        end else if (cmd.ch == CH_SLASH) begin
          kind_next  = KIND_PAT_FWD;
          phase_next = PH_PATTERN;
        end else if (cmd.ch == CH_QMARK) begin
          kind_next  = KIND_PAT_BACK;
          phase_next = PH_PATTERN;
        end else if (sign) begin
          kind_next            = KIND_CURRENT;
          term_negative_next   = (cmd.ch == CH_MINUS);
          term_value_next      = '0;
          term_has_digits_next = 1'b0;
          phase_next           = PH_TSIGN;
        end else if (digit) begin
          kind_next     = KIND_NUMBER;
          line_reg_next = {{(NB-4){1'b0}}, cmd.ch[3:0]};
          phase_next    = PH_NUMBER;
        end else begin
          consumed = 1'b0;
          finish   = 1'b1;
        end
      end
      PH_MARK: begin
        if (letter) begin
          kind_next  = KIND_MARK;
          mark_next  = cmd.ch;
          phase_next = PH_POST;
        end else begin
          consumed = 1'b0;
          err      = 1'b1;
        end
      end
      PH_PATTERN: begin
        pv = 1'b1;
        if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else if (bracket_mode == BR_OPEN) begin
          if (cmd.ch == CH_LBRACK) begin
            bracket_mode_next = BR_DOUBLE;
            prev_close_next   = 1'b0;
          end else if (cmd.ch == CH_RBRACK) begin
            bracket_mode_next = BR_NONE;
          end else begin
            bracket_mode_next = BR_SINGLE;
          end
        end else if (bracket_mode == BR_SINGLE) begin
          if (cmd.ch == CH_RBRACK) begin
            bracket_mode_next = BR_NONE;
          end
        end else if (bracket_mode == BR_DOUBLE) begin
          if (cmd.ch == CH_RBRACK && prev_close) begin
            bracket_mode_next = BR_NONE;
            prev_close_next   = 1'b0;
          end else begin
            prev_close_next = (cmd.ch == CH_RBRACK);
          end
        end else if (cmd.ch == delim) begin
          pv         = 1'b0;
          phase_next = PH_POST;
        end else if (cmd.ch == CH_BSLASH) begin
          escape_pending_next = 1'b1;
        end else if (cmd.ch == CH_LBRACK) begin
          bracket_mode_next = BR_OPEN;
        end
      end
      PH_NUMBER: begin
        if (digit) begin
          line_reg_next = ten_val;
        end else if (blank) begin
          phase_next = PH_POST;
        end else if (sign) begin
          term_negative_next   = (cmd.ch == CH_MINUS);
          term_value_next      = '0;
          term_has_digits_next = 1'b0;
          phase_next           = PH_TSIGN;
        end else begin
          consumed = 1'b0;
          finish   = 1'b1;
        end
      end
      PH_POST: begin
        if (blank) begin
        end else if (sign) begin
          term_negative_next   = (cmd.ch == CH_MINUS);
          term_value_next      = '0;
          term_has_digits_next = 1'b0;
          phase_next           = PH_TSIGN;
        end else if (digit) begin
          term_negative_next   = 1'b0;
          term_value_next      = ten_val;
          term_has_digits_next = 1'b1;
          phase_next           = PH_TDIGITS;
        end else begin
          consumed = 1'b0;
          finish   = 1'b1;
        end
      end
      PH_TSIGN, PH_TDIGITS: begin
        if (digit) begin
          term_value_next      = ten_val;
          term_has_digits_next = 1'b1;
          phase_next           = PH_TDIGITS;
        end else if (blank) begin
          if (phase == PH_TDIGITS) begin
            offset_sum_next = applied_sum;
            phase_next      = PH_POST;
          end
        end else if (sign) begin
          offset_sum_next      = applied_sum;
          term_negative_next   = (cmd.ch == CH_MINUS);
          term_value_next      = '0;
          term_has_digits_next = 1'b0;
          phase_next           = PH_TSIGN;
        end else begin
          consumed = 1'b0;
          finish   = 1'b1;
        end
      end
      default: begin
        consumed = 1'b0;
        finish   = 1'b1;
      end
    endcase

    if (!err && consumed && cmd.last) begin
      finish = 1'b1;
    end
    if (err) begin
      finish = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      kind            <= KIND_NONE;
      mark            <= '0;
      line_reg        <= '0;
      offset_sum      <= '0;
      term_value      <= '0;
      term_negative   <= 1'b0;
      term_has_digits <= 1'b0;
      bracket_mode    <= BR_NONE;
      escape_pending  <= 1'b0;
      prev_close      <= 1'b0;
    end else if (accept) begin
      if (finish || err) begin
        phase           <= PH_IDLE;
        kind            <= KIND_NONE;
        mark            <= '0;
        line_reg        <= '0;
        offset_sum      <= '0;
        term_value      <= '0;
        term_negative   <= 1'b0;
        term_has_digits <= 1'b0;
        bracket_mode    <= BR_NONE;
        escape_pending  <= 1'b0;
        prev_close      <= 1'b0;
      end else begin
        phase           <= phase_next;
        kind            <= kind_next;
        mark            <= mark_next;
        line_reg        <= line_reg_next;
        offset_sum      <= offset_sum_next;
        term_value      <= term_value_next;
        term_negative   <= term_negative_next;
        term_has_digits <= term_has_digits_next;
        bracket_mode    <= bracket_mode_next;
        escape_pending  <= escape_pending_next;
        prev_close      <= prev_close_next;
      end
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (out_load) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_consumed  <= consumed;
      s_finish    <= finish;
      s_error     <= err;
      s_pv        <= pv;
      s_ch        <= cmd.ch;
      s_kind      <= kind_next;
      s_mark      <= mark_next;
      s_line      <= line_reg_next;
      s_offset    <= offset_sum_next;
      s_term      <= term_value_next;
      s_negative  <= term_negative_next;
      s_digits    <= term_has_digits_next;
      s_term_open <= (phase_next == PH_TSIGN) || (phase_next == PH_TDIGITS);
    end
  end

  // open term is folded into the sum on the finishing transaction
  lap_offset_sat #(.NB(NB)) u_final_sat (
    .sum_in   (s_offset),
    .term     (s_digits ? s_term : ONE),
    .negative (s_negative),
    .sum_out  (final_sum)
  );

  assign final_signed = s_term_open ? final_sum : s_offset;

  always_comb begin
    res_next               = '0;
    res_next.consumed      = s_consumed;
    res_next.done_res      = s_finish;
    res_next.error         = s_error;
    res_next.pattern_valid = s_pv;
    res_next.pattern_char  = s_pv ? s_ch : 8'h00;
    if (s_finish) begin
      res_next.base_kind   = s_kind;
      res_next.mark_letter = (s_kind == KIND_MARK) ? s_mark : 8'h00;
      res_next.line_number = (s_kind == KIND_NUMBER) ? FIELD_W'(s_line) : '0;
      res_next.offset      = FIELD_W'(final_signed);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s_valid) begin
      res <= res_next;
    end
  end

  `LAP_ASSERT_NOW(a_err_not_done, res_valid && res.error, !res.done_res,
    "error and done both set")
  `LAP_ASSERT_NOW(a_summary_zero, res_valid && !res.done_res,
    res.base_kind == KIND_NONE && res.offset == 0 && res.line_number == 0,
    "summary fields set without done")
  `LAP_ASSERT_NOW(a_pattern_consumed, res_valid && res.pattern_valid, res.consumed,
    "pattern byte not consumed")
  `LAP_ASSERT_NEXT(a_restart_idle, accept && (finish || err), phase == PH_IDLE,
    "parser did not restart after finish")
  `LAP_ASSERT_NOW(a_ready_when_empty, !res_valid, cmd_ready,
    "input stalled with empty result register")

endmodule

`default_nettype wire

[test/tb_line_address_parser.sv]
// testbench for the line address parser: directed byte table, then random address streams and random byte bursts
`timescale 1ns / 1ps

module tb_line_address_parser;
  import lap_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int N_DIRECTED = 25;
  localparam longint OFS_MAX = 64'sd2147483647;
  localparam longint OFS_MIN = -64'sd2147483648;

  typedef enum logic [2:0] {
    PH_IDLE, PH_MARK, PH_PATTERN, PH_NUMBER, PH_POST, PH_TSIGN, PH_TDIGITS
  } parse_phase_e;

  typedef struct packed {
    cmd_t cmd;
    logic typed;
    res_t known_res;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic        typed;
    logic        consumed;
    logic        done_res;
    logic        error;
    logic [3:0]  kind;
    logic [7:0]  mark;
    logic [31:0] line;
    logic [31:0] ofs;
  } dir_row_t;

  // ch, last, typed, consumed, done, error, kind, mark, line, offset
  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{CH_DOT,    1'b1, 1'b1, 1'b1, 1'b1, 1'b0, KIND_CURRENT,  8'h00,    32'd0, 32'd0},
    '{CH_QUOTE,  1'b1, 1'b1, 1'b1, 1'b0, 1'b1, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_QUOTE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{8'h00,     1'b0, 1'b1, 1'b0, 1'b0, 1'b1, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{8'hff,     1'b0, 1'b1, 1'b0, 1'b1, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_TAB,    1'b1, 1'b1, 1'b1, 1'b1, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_DOLLAR, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, KIND_LAST,     8'h00,    32'd0, 32'd0},
    '{CH_RBRACK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, KIND_BLK_FWD,  8'h00,    32'd0, 32'd0},
    '{CH_LBRACK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, KIND_BLK_BACK, 8'h00,    32'd0, 32'd0},
    '{CH_QUOTE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_LC_Z,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0, KIND_MARK,     CH_LC_Z,  32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_LBRACK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_RBRACK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_MINUS,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0, KIND_PAT_FWD,  8'h00,    32'd0, 32'hffff_ffff},
    '{CH_QMARK,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_LC_A,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_QMARK,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0, KIND_PAT_BACK, 8'h00,    32'd0, 32'd0},
    '{CH_9,      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_SPACE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_NONE,     8'h00,    32'd0, 32'd0},
    '{CH_PLUS,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0, KIND_NUMBER,   8'h00,    32'd9, 32'd1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  parse_phase_e      parse_phase;
  logic [3:0]        base_kind_q;
  logic [7:0]        mark_q;
  logic [31:0]       line_q;
  logic signed [31:0] offset_q;
  logic [31:0]       term_q;
  logic              term_neg_q;
  logic              term_seen_q;
  logic [1:0]        bracket_q;
  logic              escape_q;
  logic              close_q;

  res_t       pending_results [$];
  res_t       predicted;
  cmd_item_t  cur_item = '0;
  logic [7:0] addr_text [$];
  int         mismatch_count = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  int         idle_cycles = 0;
  logic [7:0] ready_tick = '0;
  int         ready_mode = 0;

  line_address_parser DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always #5 clk = ~clk;

  function automatic void reset_parser();
    parse_phase = PH_IDLE;
    base_kind_q = KIND_NONE;
    mark_q = '0;
    line_q = '0;
    offset_q = '0;
    term_q = '0;
    term_neg_q = 1'b0;
    term_seen_q = 1'b0;
    bracket_q = BR_NONE;
    escape_q = 1'b0;
    close_q = 1'b0;
  endfunction

  function automatic logic [31:0] scale_add(logic [31:0] v, logic [7:0] d);
    logic [63:0] t;
    t = {32'd0, v} * 64'd10 + {56'd0, d};
    return (t > 64'hffff_ffff) ? 32'hffff_ffff : t[31:0];
  endfunction

  function automatic void fold_term();
    longint mag;
    longint sum;
    mag = term_seen_q ? longint'({32'd0, term_q}) : 64'sd1;
    sum = longint'(offset_q) + (term_neg_q ? -mag : mag);
    if (sum > OFS_MAX) sum = OFS_MAX;
    else if (sum < OFS_MIN) sum = OFS_MIN;
    offset_q = 32'(sum);
  endfunction

  function automatic void begin_term(logic neg);
    term_neg_q = neg;
    term_q = '0;
    term_seen_q = 1'b0;
    parse_phase = PH_TSIGN;
  endfunction

  function automatic res_t parse_char(cmd_t c);
    res_t r;
    logic blank;
    logic digit;
    logic sgn;
    logic letter;
    logic take;
    logic fin;
    logic err;
    logic pv;
    blank = (c.ch == CH_SPACE) || (c.ch == CH_TAB);
    digit = (c.ch >= CH_0) && (c.ch <= CH_9);
    sgn = (c.ch == CH_PLUS) || (c.ch == CH_MINUS);
    letter = ((c.ch >= CH_LC_A) && (c.ch <= CH_LC_Z)) ||
             ((c.ch >= CH_UC_A) && (c.ch <= CH_UC_Z));
    take = 1'b1;
    fin = 1'b0;
    err = 1'b0;
    pv = 1'b0;
    case (parse_phase)
      PH_IDLE: begin
        if (c.ch == CH_DOT) begin
          base_kind_q = KIND_CURRENT;
          parse_phase = PH_POST;
        end else if (c.ch == CH_DOLLAR) begin
          base_kind_q = KIND_LAST;
          parse_phase = PH_POST;
        end else if (c.ch == CH_RBRACK) begin
          base_kind_q = KIND_BLK_FWD;
          parse_phase = PH_POST;
        end else if (c.ch == CH_LBRACK) begin
          base_kind_q = KIND_BLK_BACK;
          parse_phase = PH_POST;
        end else if (c.ch == CH_QUOTE) begin
          parse_phase = PH_MARK;
          err = c.last;
        end else if (c.ch == CH_SLASH) begin
          base_kind_q = KIND_PAT_FWD;
          parse_phase = PH_PATTERN;
        end else if (c.ch == CH_QMARK) begin
          base_kind_q = KIND_PAT_BACK;
          parse_phase = PH_PATTERN;
        end else if (sgn) begin
          base_kind_q = KIND_CURRENT;
          begin_term(c.ch == CH_MINUS);
        end else if (digit) begin
          base_kind_q = KIND_NUMBER;
          line_q = 32'(c.ch - CH_0);
          parse_phase = PH_NUMBER;
        end else if (!blank) begin
          take = 1'b0;
          fin = 1'b1;
        end
      end
      PH_MARK: begin
        if (letter) begin
          base_kind_q = KIND_MARK;
          mark_q = c.ch;
          parse_phase = PH_POST;
        end else begin
          take = 1'b0;
          err = 1'b1;
        end
      end
      PH_PATTERN: begin
        pv = 1'b1;
        if (escape_q) begin
          escape_q = 1'b0;
        end else if (bracket_q == BR_OPEN) begin
          if (c.ch == CH_LBRACK) begin
            bracket_q = BR_DOUBLE;
            close_q = 1'b0;
          end else if (c.ch == CH_RBRACK) begin
            bracket_q = BR_NONE;
          end else begin
            bracket_q = BR_SINGLE;
          end
        end else if (bracket_q == BR_SINGLE) begin
          if (c.ch == CH_RBRACK) bracket_q = BR_NONE;
        end else if (bracket_q == BR_DOUBLE) begin
          if ((c.ch == CH_RBRACK) && close_q) begin
            bracket_q = BR_NONE;
            close_q = 1'b0;
          end else begin
            close_q = (c.ch == CH_RBRACK);
          end
        end else if (c.ch == ((base_kind_q == KIND_PAT_FWD) ? CH_SLASH : CH_QMARK)) begin
          pv = 1'b0;
          parse_phase = PH_POST;
        end else if (c.ch == CH_BSLASH) begin
          escape_q = 1'b1;
        end else if (c.ch == CH_LBRACK) begin
          bracket_q = BR_OPEN;
        end
      end
      PH_NUMBER: begin
        if (digit) begin
          line_q = scale_add(line_q, c.ch - CH_0);
        end else if (blank) begin
          parse_phase = PH_POST;
        end else if (sgn) begin
          begin_term(c.ch == CH_MINUS);
        end else begin
          take = 1'b0;
          fin = 1'b1;
        end
      end
      PH_POST: begin
        if (sgn) begin
          begin_term(c.ch == CH_MINUS);
        end else if (digit) begin
          begin_term(1'b0);
          term_q = 32'(c.ch - CH_0);
          term_seen_q = 1'b1;
          parse_phase = PH_TDIGITS;
        end else if (!blank) begin
          take = 1'b0;
          fin = 1'b1;
        end
      end
      PH_TSIGN, PH_TDIGITS: begin
        if (digit) begin
          term_q = scale_add(term_q, c.ch - CH_0);
          term_seen_q = 1'b1;
          parse_phase = PH_TDIGITS;
        end else if (blank) begin
          if (parse_phase == PH_TDIGITS) begin
            fold_term();
            parse_phase = PH_POST;
          end
        end else if (sgn) begin
          fold_term();
          begin_term(c.ch == CH_MINUS);
        end else begin
          take = 1'b0;
          fin = 1'b1;
        end
      end
      default: begin
        take = 1'b0;
        fin = 1'b1;
      end
    endcase

    if (!err && take && c.last) fin = 1'b1;
    if (fin && ((parse_phase == PH_TSIGN) || (parse_phase == PH_TDIGITS))) fold_term();

    r = '0;
    r.consumed = take;
    r.done_res = fin;
    r.error = err;
    if (fin) begin
      r.base_kind = base_kind_q;
      r.mark_letter = (base_kind_q == KIND_MARK) ? mark_q : 8'h00;
      r.line_number = (base_kind_q == KIND_NUMBER) ? line_q : 32'd0;
      r.offset = offset_q;
    end
    r.pattern_valid = pv;
    r.pattern_char = pv ? c.ch : 8'h00;
    if (fin || err) reset_parser();
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(res_t want, res_t got);
    check_field("consumed", 32'(want.consumed), 32'(got.consumed));
    check_field("done_res", 32'(want.done_res), 32'(got.done_res));
    check_field("error", 32'(want.error), 32'(got.error));
    check_field("base_kind", 32'(want.base_kind), 32'(got.base_kind));
    check_field("mark_letter", 32'(want.mark_letter), 32'(got.mark_letter));
    check_field("line_number", want.line_number, got.line_number);
    check_field("offset", want.offset, got.offset);
    check_field("pattern_valid", 32'(want.pattern_valid), 32'(got.pattern_valid));
    check_field("pattern_char", 32'(want.pattern_char), 32'(got.pattern_char));
  endtask

  // scoreboard: outputs checked before the new transaction is queued
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, res);
          mismatch_count++;
        end else begin
          check_result(pending_results.pop_front(), res);
        end
      end
      if (cmd_valid && cmd_ready) begin
        predicted = parse_char(cmd);
        pending_results.push_back(cur_item.typed ? cur_item.known_res : predicted);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver backpressure, pattern rechosen whenever ready_tick[6:0] wraps to zero
  always @(negedge clk) begin
    ready_tick <= ready_tick + 8'd1;
    if (ready_tick[6:0] == 7'd0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: res_ready <= 1'b1;
      1: res_ready <= ($urandom_range(0, 1) == 1);
      2: res_ready <= (ready_tick[2:0] != 3'd0);
      default: res_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_item(input cmd_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    cur_item = item;
    cmd <= item.cmd;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic int digit_count();
    return ($urandom_range(0, 4) == 0) ? int'($urandom_range(9, 12)) : int'($urandom_range(1, 3));
  endfunction

  task automatic push_digits(int n);
    repeat (n) addr_text.push_back(8'(CH_0 + $urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] random_letter();
    if ($urandom_range(0, 1) == 1) return 8'(CH_LC_A + $urandom_range(0, 25));
    return 8'(CH_UC_A + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pattern_byte();
    case ($urandom_range(0, 9))
      0: return CH_SLASH;
      1: return CH_QMARK;
      2: return CH_BSLASH;
      3, 4: return CH_LBRACK;
      5, 6: return CH_RBRACK;
      7: return CH_SPACE;
      8: return 8'($urandom_range(0, 255));
      default: return random_letter();
    endcase
  endfunction

  task automatic build_address();
    logic [7:0] delim;
    int sel;
    addr_text.delete();
    repeat ($urandom_range(0, 2)) begin
      addr_text.push_back(($urandom_range(0, 1) == 1) ? CH_SPACE : CH_TAB);
    end
    case ($urandom_range(0, 9))
      0: ;
      1: addr_text.push_back(CH_DOT);
      2: addr_text.push_back(CH_DOLLAR);
      3: addr_text.push_back(CH_RBRACK);
      4: addr_text.push_back(CH_LBRACK);
      5: begin
        addr_text.push_back(CH_QUOTE);
        addr_text.push_back(($urandom_range(0, 7) == 0) ?
                            8'($urandom_range(0, 255)) : random_letter());
      end
      6, 7: begin
        delim = ($urandom_range(0, 1) == 1) ? CH_SLASH : CH_QMARK;
        addr_text.push_back(delim);
        repeat ($urandom_range(0, 8)) addr_text.push_back(pattern_byte());
        if ($urandom_range(0, 7) != 0) addr_text.push_back(delim);
      end
      8: push_digits(digit_count());
      default: addr_text.push_back(($urandom_range(0, 1) == 1) ? CH_PLUS : CH_MINUS);
    endcase
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 2) == 0) addr_text.push_back(CH_SPACE);
      sel = $urandom_range(0, 2);
      if (sel != 2) addr_text.push_back((sel == 0) ? CH_PLUS : CH_MINUS);
      if ((sel == 2) || ($urandom_range(0, 2) != 0)) push_digits(digit_count());
    end
  endtask

  initial begin
    cmd_item_t item;
    dir_row_t row;
    int ending;
    reset_parser();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      item = '0;
      item.cmd.ch = row.ch;
      item.cmd.last = row.last;
      item.typed = row.typed;
      item.known_res.consumed = row.consumed;
      item.known_res.done_res = row.done_res;
      item.known_res.error = row.error;
      item.known_res.base_kind = row.kind;
      item.known_res.mark_letter = row.mark;
      item.known_res.line_number = row.line;
      item.known_res.offset = row.ofs;
      send_item(item);
    end
    drain_results();

    while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
      item = '0;
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          item.cmd.ch = 8'($urandom_range(0, 255));
          item.cmd.last = ($urandom_range(0, 3) == 0);
          send_item(item);
        end
      end else begin
        build_address();
        // 0: stray command byte, 1-2: end of string, 3: runs on
        ending = $urandom_range(0, 3);
        if (ending == 0) begin
          addr_text.push_back(($urandom_range(0, 1) == 1) ?
                              8'($urandom_range(0, 255)) : random_letter());
        end
        foreach (addr_text[k]) begin
          item.cmd.ch = addr_text[k];
          item.cmd.last = ((ending == 1) || (ending == 2)) && (k == addr_text.size() - 1);
          send_item(item);
        end
      end
      if ($urandom_range(0, 59) == 0) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
